FILE: src/hrc_pkg.sv
`default_nettype none

package hrc_pkg;

  localparam int CHANNEL_BITS_DEF = 8;
  localparam int HUE_BITS         = 9;
  localparam int RAMP_T_BITS      = 6;

  localparam logic [HUE_BITS-1:0] HUE_PERIOD = 9'd360;
  localparam logic [HUE_BITS-1:0] HUE_THIRD  = 9'd120;
  localparam logic [HUE_BITS-1:0] HUE_TWO3RD = 9'd240;
  localparam logic [HUE_BITS-1:0] EDGE_RISE  = 9'd60;
  localparam logic [HUE_BITS-1:0] EDGE_HIGH  = 9'd180;
  localparam logic [HUE_BITS-1:0] EDGE_FALL  = 9'd240;

  // ramp segment for one channel
  typedef enum logic [1:0] {
    SEG_RISE,
    SEG_HIGH,
    SEG_FALL,
    SEG_LOW
  } seg_e;

  typedef struct packed {
    seg_e                   seg;
    logic [RAMP_T_BITS-1:0] t;    // distance into the sloped segment, 0..60
  } ramp_t;

  function automatic logic [HUE_BITS-1:0] wrap_add(input logic [HUE_BITS-1:0] h);
    // h in 0..359, returns (h + 120) mod 360
    if (h < HUE_TWO3RD) begin
      return h + HUE_THIRD;
    end
    return h - HUE_TWO3RD;
  endfunction

  function automatic logic [HUE_BITS-1:0] wrap_sub(input logic [HUE_BITS-1:0] h);
    // h in 0..359, returns (h - 120) mod 360
    if (h < HUE_THIRD) begin
      return h + HUE_TWO3RD;
    end
    return h - HUE_THIRD;
  endfunction

  function automatic ramp_t ramp_desc(input logic [HUE_BITS-1:0] x);
    ramp_t d;
    logic [HUE_BITS-1:0] back;
    back = EDGE_FALL - x;
    d.t  = '0;
    if (x < EDGE_RISE) begin
      d.seg = SEG_RISE;
      d.t   = x[RAMP_T_BITS-1:0];
    end else if (x < EDGE_HIGH) begin
      d.seg = SEG_HIGH;
    end else if (x < EDGE_FALL) begin
      d.seg = SEG_FALL;
      d.t   = back[RAMP_T_BITS-1:0];
    end else begin
      d.seg = SEG_LOW;
    end
    return d;
  endfunction

endpackage

`default_nettype wire

FILE: src/hrc_in_if.sv
`default_nettype none

interface hrc_in_if import hrc_pkg::*; #(
  parameter int ChannelBits = CHANNEL_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [HUE_BITS-1:0]    hue;
  logic [ChannelBits-1:0] lightness;
  logic [ChannelBits-1:0] saturation;

  modport source (output valid, output hue, output lightness, output saturation,
                  input ready);
  modport sink   (input valid, input hue, input lightness, input saturation,
                  output ready);
endinterface

`default_nettype wire

FILE: src/hrc_out_if.sv
`default_nettype none

interface hrc_out_if import hrc_pkg::*; #(
  parameter int ChannelBits = CHANNEL_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [ChannelBits-1:0] red;
  logic [ChannelBits-1:0] green;
  logic [ChannelBits-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

FILE: src/hrc_levels.sv
`default_nettype none

// Stages 1 and 2: L*S product, division by full scale, p1/p2 and ramp descriptors.
module hrc_levels import hrc_pkg::*; #(
  parameter int ChannelBits = CHANNEL_BITS_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   en_i,
  input  wire logic [HUE_BITS-1:0]    hue_i,
  input  wire logic [ChannelBits-1:0] light_i,
  input  wire logic [ChannelBits-1:0] sat_i,
  output logic      [ChannelBits-1:0] p1_o,
  output logic      [ChannelBits-1:0] p2_o,
  output logic      [ChannelBits-1:0] span_o,
  output ramp_t                       desc_r_o,
  output ramp_t                       desc_g_o,
  output ramp_t                       desc_b_o
);

  localparam int CB = ChannelBits;
  localparam logic [CB+1:0] FullW = {2'b00, {CB{1'b1}}};

  // stage 1
  logic [HUE_BITS-1:0] hue_q;
  logic [CB-1:0]       light_q, sat_q;
  logic [2*CB-1:0]     prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hue_q   <= (hue_i >= HUE_PERIOD) ? hue_i - HUE_PERIOD : hue_i;
      light_q <= light_i;
      sat_q   <= sat_i;
      prod_q  <= light_i * sat_i;
    end
  end

  // stage 2: floor(prod / (2^CB - 1)) with a single correction step
  logic [CB-1:0]   quo;
  logic [CB:0]     rem;
  logic [CB-1:0]   ls_div;
  logic [CB+1:0]   p2_raw, p2_c;
  logic signed [CB+2:0] p1_raw;
  logic [CB+1:0]   p1_c;
  logic signed [CB+2:0] span_raw;
  logic [CB-1:0]   span_c;

  always_comb begin
    quo    = prod_q[2*CB-1:CB];
    rem    = {1'b0, prod_q[CB-1:0]} + {1'b0, quo};
    ls_div = (rem >= FullW[CB:0]) ? quo + 1'b1 : quo;
    if (!light_q[CB-1]) begin
      p2_raw = {2'b00, light_q} + {2'b00, ls_div};
    end else begin
      p2_raw = {2'b00, light_q} + {2'b00, sat_q} - {2'b00, ls_div};
    end
    p2_c   = (p2_raw > FullW) ? FullW : p2_raw;
    p1_raw = $signed({2'b00, light_q, 1'b0}) - $signed({1'b0, p2_c});
    if (p1_raw < 0) begin
      p1_c = '0;
    end else if (p1_raw > $signed({1'b0, FullW})) begin
      p1_c = FullW;
    end else begin
      p1_c = p1_raw[CB+1:0];
    end
    span_raw = $signed({1'b0, p2_c}) - $signed({1'b0, p1_c});
    span_c   = (span_raw < 0) ? '0 : span_raw[CB-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1_o     <= p1_c[CB-1:0];
      p2_o     <= p2_c[CB-1:0];
      span_o   <= span_c;
      desc_r_o <= ramp_desc(wrap_add(hue_q));
      desc_g_o <= ramp_desc(hue_q);
      desc_b_o <= ramp_desc(wrap_sub(hue_q));
    end
  end

endmodule

`default_nettype wire

FILE: src/hrc_ramp.sv
`default_nettype none

// Stages 3 to 5 of one channel: span*t, divide by 60 by reciprocal, select segment.
module hrc_ramp import hrc_pkg::*; #(
  parameter int ChannelBits = CHANNEL_BITS_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   en_i,
  input  wire logic [ChannelBits-1:0] p1_i,
  input  wire logic [ChannelBits-1:0] p2_i,
  input  wire logic [ChannelBits-1:0] span_i,
  input  wire ramp_t                  desc_i,
  output logic      [ChannelBits-1:0] level_o
);

  localparam int CB       = ChannelBits;
  localparam int ProdW    = CB + RAMP_T_BITS;
  localparam int Shift    = ProdW + 6;
  localparam longint RecipL = ((longint'(1) << Shift) + 59) / 60;
  localparam int RecipW   = Shift - 5;
  localparam logic [RecipW-1:0] Recip = RecipW'(RecipL);

  // stage 3
  logic [ProdW-1:0] mul_q;
  logic [CB-1:0]    p1_3_q, p2_3_q;
  seg_e             seg_3_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mul_q   <= span_i * desc_i.t;
      p1_3_q  <= p1_i;
      p2_3_q  <= p2_i;
      seg_3_q <= desc_i.seg;
    end
  end

  // stage 4
  logic [ProdW+RecipW-1:0] rcp_q;
  logic [CB-1:0]           p1_4_q, p2_4_q;
  seg_e                    seg_4_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rcp_q   <= mul_q * Recip;
      p1_4_q  <= p1_3_q;
      p2_4_q  <= p2_3_q;
      seg_4_q <= seg_3_q;
    end
  end

  // stage 5
  logic [ProdW+RecipW-1:0] quo_full;
  logic [CB-1:0]           step;
  logic [CB-1:0]           level_d;

  always_comb begin
    quo_full = rcp_q >> Shift;
    step     = quo_full[CB-1:0];
    case (seg_4_q)
      SEG_RISE: level_d = p1_4_q + step;
      SEG_HIGH: level_d = p2_4_q;
      SEG_FALL: level_d = p1_4_q + step;
      SEG_LOW:  level_d = p1_4_q;
      default:  level_d = p1_4_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      level_o <= level_d;
    end
  end

endmodule

`default_nettype wire

FILE: src/hls_to_rgb_converter_core.sv
`default_nettype none

// Channel   Dir  Payload                              Handshake
// col_i     in   hue[8:0], lightness, saturation      valid/ready
// col_o     out  red, green, blue                     valid/ready
//
// Five register stages; one colour enters every cycle unless col_o stalls,
// and each result is offered on col_o once it reaches the last stage.
// rst_ni clears only the stage valid bits; payload registers are not reset.
// A stall on col_o freezes every stage together, so col_i.ready falls only
// while the output stage holds a result that has not been taken.
module hls_to_rgb_converter_core import hrc_pkg::*; #(
  parameter int ChannelBits = CHANNEL_BITS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  hrc_in_if.sink    col_i,
  hrc_out_if.source col_o
);

  localparam int Depth = 5;

  logic [Depth-1:0] vld_q, vld_d;
  logic             adv;

  // advance the whole pipe unless the output stage is full and stalled
  assign adv         = !vld_q[Depth-1] || col_o.ready;
  assign col_i.ready = adv;
  assign col_o.valid = vld_q[Depth-1];

  always_comb begin
    vld_d = vld_q;
    if (adv) begin
      vld_d = {vld_q[Depth-2:0], col_i.valid};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  logic [ChannelBits-1:0] p1, p2, span;
  ramp_t                  desc_r, desc_g, desc_b;

  // levels p1/p2 and per-channel ramp positions
  hrc_levels #(.ChannelBits(ChannelBits)) u_levels (
    .clk_i    (clk_i),
    .en_i     (adv),
    .hue_i    (col_i.hue),
    .light_i  (col_i.lightness),
    .sat_i    (col_i.saturation),
    .p1_o     (p1),
    .p2_o     (p2),
    .span_o   (span),
    .desc_r_o (desc_r),
    .desc_g_o (desc_g),
    .desc_b_o (desc_b)
  );

  // one ramp per channel: red at hue+120, green at hue, blue at hue-120
  hrc_ramp #(.ChannelBits(ChannelBits)) u_ramp_r (
    .clk_i   (clk_i),
    .en_i    (adv),
    .p1_i    (p1),
    .p2_i    (p2),
    .span_i  (span),
    .desc_i  (desc_r),
    .level_o (col_o.red)
  );

  hrc_ramp #(.ChannelBits(ChannelBits)) u_ramp_g (
    .clk_i   (clk_i),
    .en_i    (adv),
    .p1_i    (p1),
    .p2_i    (p2),
    .span_i  (span),
    .desc_i  (desc_g),
    .level_o (col_o.green)
  );

  hrc_ramp #(.ChannelBits(ChannelBits)) u_ramp_b (
    .clk_i   (clk_i),
    .en_i    (adv),
    .p1_i    (p1),
    .p2_i    (p2),
    .span_i  (span),
    .desc_i  (desc_b),
    .level_o (col_o.blue)
  );

endmodule

`default_nettype wire
